FILE: design/ofd_pkg.sv
package ofd_pkg;

  // Frame layout.
  localparam int unsigned FRAME_LEN  = 18;
  localparam int unsigned CHECK_POS  = 17;
  localparam int unsigned FAULT_POS  = 16;
  localparam int unsigned WORD_BYTES = 16;

  localparam logic [7:0] ENCODER_FAULT = 8'd1;

  // Status codes of a finished frame.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_CHECKSUM = 2'd1;
  localparam logic [1:0] STATUS_FAULT    = 2'd2;

  // One received byte with its start flag.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } ofd_item_t;

  // One decoded frame.
  typedef struct packed {
    logic signed [31:0] right_ticks;
    logic signed [31:0] left_ticks;
    logic signed [31:0] right_speed;
    logic signed [31:0] left_speed;
    logic        [1:0]  frame_status;
  } ofd_result_t;

endpackage

FILE: design/ofd_in_reg.sv
module ofd_in_reg import ofd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ofd_item_t in_item_i,
  input  logic      advance_i,
  output logic      item_valid_o,
  output ofd_item_t item_o
);

  logic      valid_q, valid_d;
  ofd_item_t item_q;
  logic      take;

  // The register takes a new transaction when empty or when its item moves on.
  assign take       = !valid_q || advance_i;
  assign in_stall_o = !take;
  assign valid_d    = in_valid_i ? 1'b1 : (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

FILE: design/ofd_assembler.sv
module ofd_assembler import ofd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  ofd_item_t   item_i,
  output logic        res_valid_o,
  output ofd_result_t res_o
);

  logic [4:0]       pos_q, pos_d, pos_eff;
  logic [7:0]       xor_q, xor_d, xor_eff;
  logic [15:0][7:0] bytes_q;
  logic [7:0]       fault_q;
  logic             is_check;

  // A start flag, or a counter past the frame, restarts at byte zero.
  always_comb begin
    if (item_i.frame_start || (pos_q >= 5'(FRAME_LEN))) begin
      pos_eff = '0;
      xor_eff = '0;
    end else begin
      pos_eff = pos_q;
      xor_eff = xor_q;
    end
  end

  assign is_check = (pos_eff == 5'(CHECK_POS));

  // Next counter and checksum state.
  always_comb begin
    if (is_check) begin
      pos_d = '0;
      xor_d = '0;
    end else begin
      pos_d = pos_eff + 5'd1;
      xor_d = xor_eff ^ item_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      xor_q <= '0;
    end else if (fire_i) begin
      pos_q <= pos_d;
      xor_q <= xor_d;
    end
  end

  // Word bytes and the error byte are stored in place.
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      if (pos_eff < 5'(WORD_BYTES)) begin
        bytes_q[pos_eff[3:0]] <= item_i.rx_byte;
      end else if (pos_eff == 5'(FAULT_POS)) begin
        fault_q <= item_i.rx_byte;
      end
    end
  end

  // The checksum mismatch takes precedence over the encoder fault.
  always_comb begin
    res_o.right_ticks = bytes_q[3:0];
    res_o.left_ticks  = bytes_q[7:4];
    res_o.right_speed = bytes_q[11:8];
    res_o.left_speed  = bytes_q[15:12];
    priority if (item_i.rx_byte != xor_eff) begin
      res_o.frame_status = STATUS_CHECKSUM;
    end else if (fault_q == ENCODER_FAULT) begin
      res_o.frame_status = STATUS_FAULT;
    end else begin
      res_o.frame_status = STATUS_OK;
    end
  end

  assign res_valid_o = fire_i && is_check;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= 5'(CHECK_POS))
    else $error("byte counter ran past the checksum byte");

  a_xor_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q == 5'd0) |-> (xor_q == 8'd0))
    else $error("checksum not cleared at frame boundary");

  a_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (pos_q == 5'd0))
    else $error("counter did not wrap after a finished frame");

endmodule

FILE: design/ofd_out_reg.sv
module ofd_out_reg import ofd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        res_valid_i,
  input  ofd_result_t res_i,
  output logic        ready_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output ofd_result_t res_o
);

  logic        valid_q;
  ofd_result_t res_q;

  // The register is free when empty or when its transaction leaves now.
  assign ready_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

FILE: design/odometry_frame_decoder.sv
// Channel  Handshake               Payload
// in       in_valid_i/in_stall_o   rx_byte_i, frame_start_i
// out      out_valid_o/out_stall_i right_ticks_o, left_ticks_o, right_speed_o,
//                                  left_speed_o, frame_status_o
//
// One byte is taken every cycle unless the output stalls; the counter and
// checksum update in the decode stage as each byte is decoded.
// A frame result is decoded from the input register into the output register.
// Reset clears the byte counter, the checksum and both valid flags.
// A stalled output holds its result and backs up into the input register.
module odometry_frame_decoder import ofd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               frame_start_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] right_ticks_o,
  output logic signed [31:0] left_ticks_o,
  output logic signed [31:0] right_speed_o,
  output logic signed [31:0] left_speed_o,
  output logic        [1:0]  frame_status_o
);

  ofd_item_t   in_item, item;
  ofd_result_t res, res_out;
  logic        item_valid, out_ready, fire, res_valid;

  assign in_item.rx_byte     = rx_byte_i;
  assign in_item.frame_start = frame_start_i;

  ofd_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item),
    .advance_i    (out_ready),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  // A byte is decoded once the result register can take what it makes.
  assign fire = item_valid && out_ready;

  ofd_assembler u_assembler (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ofd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign right_ticks_o  = res_out.right_ticks;
  assign left_ticks_o   = res_out.left_ticks;
  assign right_speed_o  = res_out.right_speed;
  assign left_speed_o   = res_out.left_speed;
  assign frame_status_o = res_out.frame_status;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked output");

  a_no_fire_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !fire)
    else $error("byte decoded while the result register was blocked");

endmodule

FILE: bench/tb_odometry_frame_decoder.sv
module tb_odometry_frame_decoder;
  import ofd_pkg::*;

  localparam int ITEM_GOAL    = 1650;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 10;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         rx_byte_i;
  logic               frame_start_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] right_ticks_o;
  logic signed [31:0] left_ticks_o;
  logic signed [31:0] right_speed_o;
  logic signed [31:0] left_speed_o;
  logic        [1:0]  frame_status_o;

  // Shared run state.
  int  err_count;
  int  bytes_sent;
  bit  quiet;
  bit  hold_off_req;
  bit  hold_active;

  // Decoded frames that the block still owes us, oldest first.
  ofd_result_t pending_frames[$];

  // Our own copy of the decoder state.
  logic [4:0]  frame_pos;
  logic [7:0]  frame_xor;
  logic [31:0] frame_words [4];
  logic [7:0]  frame_fault;

  odometry_frame_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .frame_start_i  (frame_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .right_ticks_o  (right_ticks_o),
    .left_ticks_o   (left_ticks_o),
    .right_speed_o  (right_speed_o),
    .left_speed_o   (left_speed_o),
    .frame_status_o (frame_status_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Advance the decoder state by one byte and queue a frame when the checksum byte lands.
  function automatic void decode_byte(input logic [7:0] rx_val, input logic start_flag);
    ofd_result_t frame;
    if (start_flag) begin
      frame_pos = '0;
      frame_xor = '0;
    end
    if (frame_pos >= FRAME_LEN) begin
      frame_pos = '0;
    end
    if (frame_pos < CHECK_POS) begin
      if (frame_pos < WORD_BYTES) begin
        frame_words[frame_pos[3:2]][8*frame_pos[1:0] +: 8] = rx_val;
      end else begin
        frame_fault = rx_val;
      end
      frame_xor = frame_xor ^ rx_val;
      frame_pos = frame_pos + 5'd1;
    end else begin
      frame.right_ticks = frame_words[0];
      frame.left_ticks  = frame_words[1];
      frame.right_speed = frame_words[2];
      frame.left_speed  = frame_words[3];
      // A bad checksum outranks an encoder fault.
      if (rx_val != frame_xor) begin
        frame.frame_status = STATUS_CHECKSUM;
      end else if (frame_fault == ENCODER_FAULT) begin
        frame.frame_status = STATUS_FAULT;
      end else begin
        frame.frame_status = STATUS_OK;
      end
      pending_frames.push_back(frame);
      frame_pos = '0;
      frame_xor = '0;
    end
  endfunction

  // Offer one byte after a random gap and hold it until the transaction completes.
  task automatic send_byte(input logic [7:0] rx_val, input logic start_flag);
    int gap;
    int pick;
    pick = $urandom_range(99);
    if (quiet || pick < 55) begin
      gap = 0;
    end else if (pick < 90) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 40);
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    rx_byte_i     <= rx_val;
    frame_start_i <= start_flag;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    decode_byte(rx_val, start_flag);
    bytes_sent++;
  endtask

  // Drop valid before any pause so that a stale byte is not taken twice.
  task automatic end_burst();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Send the first len bytes of a frame built from four words and a fault byte.
  task automatic send_frame(input logic [127:0] words, input logic [7:0] fault,
                            input bit corrupt, input bit flag_start, input int len);
    logic [7:0] frame_bytes [FRAME_LEN];
    logic [7:0] sum;
    int i;
    sum = '0;
    for (i = 0; i < WORD_BYTES; i++) begin
      frame_bytes[i] = words[8*i +: 8];
      sum = sum ^ frame_bytes[i];
    end
    frame_bytes[FAULT_POS] = fault;
    sum = sum ^ fault;
    frame_bytes[CHECK_POS] = corrupt ? (sum ^ 8'($urandom_range(1, 255))) : sum;
    for (i = 0; i < len; i++) begin
      send_byte(frame_bytes[i], flag_start && (i == 0));
    end
  endtask

  // Word values lean toward the signed extremes, zero, all ones and small values.
  function automatic logic [31:0] random_word();
    case ($urandom_range(9))
      0: random_word = 32'h7FFF_FFFF;
      1: random_word = 32'h8000_0000;
      2: random_word = 32'h0000_0000;
      3: random_word = 32'hFFFF_FFFF;
      4: random_word = $urandom_range(200) - 100;
      default: random_word = $urandom;
    endcase
  endfunction

  // Bytes without a start flag right after reset, then a restart into a faulted frame.
  task automatic test_restart_after_partial();
    send_byte(8'hA5, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_frame({32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF},
               ENCODER_FAULT, 1'b0, 1'b1, FRAME_LEN);
  endtask

  // The receiver holds off for a long stretch while frames keep arriving back to back.
  task automatic test_output_hold_off();
    int n;
    end_burst();
    quiet        = 1'b1;
    hold_off_req = 1'b1;
    wait (hold_active);
    for (n = 0; n < 4; n++) begin
      send_frame({random_word(), random_word(), random_word(), random_word()},
                 8'($urandom_range(255)), 1'b0, 1'b1, FRAME_LEN);
    end
    quiet = 1'b0;
  endtask

  // Mostly well-formed frames, plus truncated frames, bad checksums and noise.
  task automatic test_random_frames(input int item_goal);
    int kind;
    int len;
    bit need_sync;
    logic [7:0] fault;
    need_sync = 1'b0;
    while (bytes_sent < item_goal) begin
      // One stretch runs with no idling on either side.
      quiet = (bytes_sent > item_goal * 2 / 5) && (bytes_sent < item_goal / 2);
      kind  = $urandom_range(99);
      fault = ($urandom_range(3) == 0) ? ENCODER_FAULT : 8'($urandom_range(255));
      if (kind < 8) begin
        repeat ($urandom_range(1, 6)) begin
          send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
        end
        need_sync = 1'b1;
      end else begin
        len = (kind < 20) ? $urandom_range(1, FRAME_LEN - 1) : FRAME_LEN;
        send_frame({random_word(), random_word(), random_word(), random_word()}, fault,
                   $urandom_range(5) == 0, need_sync || ($urandom_range(4) != 0), len);
        need_sync = (len != FRAME_LEN);
      end
    end
    quiet = 1'b0;
  endtask

  // Receiver stall pattern, with one long hold-off on request.
  initial begin : stall_gen
    int stall_len;
    int run_len;
    int pick;
    out_stall_i <= 1'b0;
    hold_active  = 1'b0;
    @(posedge clk_i);
    forever begin
      pick = $urandom_range(99);
      if (hold_off_req) begin
        stall_len   = HOLD_CYCLES;
        hold_active = 1'b1;
      end else if (quiet || pick < 50) begin
        stall_len = 0;
      end else if (pick < 90) begin
        stall_len = $urandom_range(1, 3);
      end else begin
        stall_len = $urandom_range(8, 40);
      end
      run_len = $urandom_range(1, 12);
      if (stall_len != 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_len) @(posedge clk_i);
        if (hold_active) begin
          hold_active  = 1'b0;
          hold_off_req = 1'b0;
        end
      end
      out_stall_i <= 1'b0;
      repeat (run_len) @(posedge clk_i);
    end
  end

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endfunction

  // Compare every output transaction with the oldest pending frame.
  always @(posedge clk_i) begin : result_check
    ofd_result_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_frames.size() == 0) begin
        err_count++;
        $display("%0t: unexpected frame, expected none, actual status %h", $time,
                 frame_status_o);
      end else begin
        want = pending_frames.pop_front();
        check_field("right_ticks", want.right_ticks, right_ticks_o);
        check_field("left_ticks", want.left_ticks, left_ticks_o);
        check_field("right_speed", want.right_speed, right_speed_o);
        check_field("left_speed", want.left_speed, left_speed_o);
        check_field("frame_status", 32'(want.frame_status), 32'(frame_status_o));
      end
    end
  end

  // End the run when no transaction happens on either channel for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    wait (rst_ni === 1'b1);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
          (out_valid_o === 1'b1 && out_stall_i === 1'b0)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("odometry_frame_decoder test failed");
    $finish;
  end

  // Reset, run the tests in turn, drain and report.
  initial begin
    in_valid_i    <= 1'b0;
    rx_byte_i     <= '0;
    frame_start_i <= 1'b0;
    rst_ni        <= 1'b0;
    err_count    = 0;
    bytes_sent   = 0;
    quiet        = 1'b0;
    hold_off_req = 1'b0;
    frame_pos    = '0;
    frame_xor    = '0;
    frame_fault  = '0;
    foreach (frame_words[i]) frame_words[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_restart_after_partial();
    test_output_hold_off();
    test_random_frames(ITEM_GOAL);

    end_burst();
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("odometry_frame_decoder test passed");
    end else begin
      $display("odometry_frame_decoder test failed");
    end
    $finish;
  end

endmodule
